[hdl/hce_pkg.sv]
package hce_pkg;

  localparam int MAX_CODE_BITS_DEF = 64;
  localparam int WORD_W            = 64;
  localparam int LEN_W             = 6;
  localparam int PAR_W             = 3;
  localparam int SYN_W             = 7;
  localparam logic [LEN_W-1:0] DATA_LEN_RST = 6'd4;

  typedef struct packed {
    logic              req_type;
    logic [WORD_W-1:0] word;
  } hce_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] code_word;
    logic [SYN_W-1:0]  syndrome;
    logic              error_found;
    logic [PAR_W-1:0]  parity_count;
  } hce_out_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [PAR_W-1:0] par;
    logic [SYN_W-1:0] total;
  } hce_cfg_t;

  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_CHECK  = 1'b1;

  function automatic logic [PAR_W-1:0] parity_bits(input logic [SYN_W-1:0] n);
    int r;
    r = 0;
    for (int i = 0; i < 8; i++) begin
      if ((1 << r) < int'(n) + r + 1) begin
        r++;
      end
    end
    return PAR_W'(r);
  endfunction

  function automatic int max_len(input int max_bits);
    int best;
    best = 1;
    for (int n = 1; n < (1 << LEN_W); n++) begin
      if (n + int'(parity_bits(SYN_W'(n))) <= max_bits) begin
        best = n;
      end
    end
    return best;
  endfunction

  function automatic hce_cfg_t cfg_of(input logic [LEN_W-1:0] raw, input int nmax);
    hce_cfg_t c;
    logic [LEN_W-1:0] n;
    n = (raw == '0) ? LEN_W'(1) : raw;
    if (int'(n) > nmax) begin
      n = LEN_W'(nmax);
    end
    c.len   = n;
    c.par   = parity_bits({1'b0, n});
    c.total = {1'b0, n} + {4'b0000, c.par};
    return c;
  endfunction

  function automatic bit is_pow2(input int k);
    return (k & (k - 1)) == 0;
  endfunction

  // Data bit index carried by a position that is not a power of two.
  function automatic int data_idx(input int k);
    int cnt;
    cnt = 0;
    for (int i = 0; i < SYN_W; i++) begin
      if ((1 << i) <= k) begin
        cnt++;
      end
    end
    return k - 1 - cnt;
  endfunction

  // Positions whose 1-based index has the given bit set.
  function automatic logic [WORD_W-1:0] sel_mask(input int i);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int k = 1; k <= WORD_W; k++) begin
      m[k-1] = ((k >> i) & 1) != 0;
    end
    return m;
  endfunction

endpackage

[hdl/hamming_code_encode_check.sv]
// Channel  Ports                              Direction  Handshake
// input    start, busy, in_data               in         start high and busy low
// result   out_valid, out_data                out        out_valid strobe, one cycle
// config   cfg_valid, cfg_ready, cfg_data     in         cfg_valid and cfg_ready high
//
// A word is taken in every cycle; busy is never raised.
// Each result appears once its word has passed the register stages, for one cycle only.
// The three register stages are masking and placement,
// syndrome parity trees, and result assembly.
// Reset clears the pipeline valid bits and sets the data length to four.
// The receiver cannot stall, so no result is ever held back.
module hamming_code_encode_check #(
  parameter int MAX_CODE_BITS = hce_pkg::MAX_CODE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  hce_pkg::hce_in_t           in_data,
  output logic                       out_valid,
  output hce_pkg::hce_out_t          out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [hce_pkg::LEN_W-1:0]  cfg_data
);
  import hce_pkg::*;

  localparam int NMAX = max_len(MAX_CODE_BITS);

  hce_cfg_t cfg_r;
  logic     accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= cfg_of(DATA_LEN_RST, NMAX);
    end else if (cfg_valid && cfg_ready) begin
      cfg_r <= cfg_of(cfg_data, NMAX);
    end
  end

  hce_pipe #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (accept),
    .in_data (in_data),
    .cfg     (cfg_r),
    .out_vld (out_valid),
    .out_data(out_data)
  );

endmodule

[hdl/hce_pipe.sv]
module hce_pipe #(
  parameter int MAX_CODE_BITS = hce_pkg::MAX_CODE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  hce_pkg::hce_in_t in_data,
  input  hce_pkg::hce_cfg_t cfg,
  output logic             out_vld,
  output hce_pkg::hce_out_t out_data
);
  import hce_pkg::*;

  logic [WORD_W-1:0]        data_m;
  logic [MAX_CODE_BITS-1:0] enc_pos;
  logic [MAX_CODE_BITS-1:0] chk_pos;
  logic [MAX_CODE_BITS-1:0] par_vec;
  logic [MAX_CODE_BITS-1:0] s1_pos_nxt;
  logic [SYN_W-1:0]         syn_nxt;
  hce_out_t                 out_nxt;

  logic                     s1_vld_r;
  logic                     s1_type_r;
  logic [PAR_W-1:0]         s1_par_r;
  logic [MAX_CODE_BITS-1:0] s1_pos_r;
  logic                     s2_vld_r;
  logic                     s2_type_r;
  logic [PAR_W-1:0]         s2_par_r;
  logic [MAX_CODE_BITS-1:0] s2_pos_r;
  logic [SYN_W-1:0]         s2_syn_r;
  logic                     out_vld_r;
  hce_out_t                 out_data_r;

  // Stage one: mask unused bits and spread the data over the code positions, or on check mask the received word.
  assign data_m  = in_data.word & ~({WORD_W{1'b1}} << cfg.len);
  assign chk_pos = in_data.word[MAX_CODE_BITS-1:0] & ~({MAX_CODE_BITS{1'b1}} << cfg.total);

  for (genvar k = 1; k <= MAX_CODE_BITS; k++) begin : g_pos
    if (is_pow2(k)) begin : g_par
      assign enc_pos[k-1] = 1'b0;
      assign par_vec[k-1] = s2_syn_r[$clog2(k)];
    end else begin : g_dat
      assign enc_pos[k-1] = data_m[data_idx(k)];
      assign par_vec[k-1] = 1'b0;
    end
  end

  assign s1_pos_nxt = (in_data.req_type == REQ_CHECK) ? chk_pos : enc_pos;

  // Stage two: each syndrome bit is the parity of the positions selecting it.
  for (genvar i = 0; i < SYN_W; i++) begin : g_syn
    localparam logic [WORD_W-1:0] SEL = sel_mask(i);
    assign syn_nxt[i] = ^(s1_pos_r & SEL[MAX_CODE_BITS-1:0]);
  end

  // Stage three: on encode the parity bits sit at the power-of-two positions; on check the syndrome is given.
  always_comb begin
    out_nxt.parity_count = s2_par_r;
    if (s2_type_r == REQ_CHECK) begin
      out_nxt.code_word   = '0;
      out_nxt.syndrome    = s2_syn_r;
      out_nxt.error_found = (s2_syn_r != '0);
    end else begin
      out_nxt.code_word   = WORD_W'(s2_pos_r | par_vec);
      out_nxt.syndrome    = '0;
      out_nxt.error_found = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= in_vld;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_type_r  <= in_data.req_type;
    s1_par_r   <= cfg.par;
    s1_pos_r   <= s1_pos_nxt;
    s2_type_r  <= s1_type_r;
    s2_par_r   <= s1_par_r;
    s2_pos_r   <= s1_pos_r;
    s2_syn_r   <= syn_nxt;
    out_data_r <= out_nxt;
  end

  assign out_vld  = out_vld_r;
  assign out_data = out_data_r;

endmodule

[hdl/hce_checker.sv]
module hce_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input hce_pkg::hce_in_t          in_data,
  input logic                      out_valid,
  input hce_pkg::hce_out_t         out_data
);
  import hce_pkg::*;

  logic [2:0] rst_hist_r;
  logic       settled;

  always_ff @(posedge clk) begin
    rst_hist_r <= {rst_hist_r[1:0], rst_n};
  end

  assign settled = &rst_hist_r;

  // Every accepted word gives exactly one result once it has passed the pipeline.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    settled |-> (out_valid == $past(start && !busy, 3)))
    else $error("result strobe does not match an accepted word");

  a_err_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.error_found == (out_data.syndrome != '0)))
    else $error("error flag disagrees with syndrome");

  a_enc_no_syn: assert property (@(posedge clk) disable iff (!rst_n)
    (settled && out_valid && $past(in_data.req_type == REQ_ENCODE, 3))
      |-> (out_data.syndrome == '0 && !out_data.error_found))
    else $error("encode result carries a syndrome");

  a_chk_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    (settled && out_valid && $past(in_data.req_type == REQ_CHECK, 3))
      |-> (out_data.code_word == '0 && out_data.parity_count != '0))
    else $error("check result carries a code word or no parity count");

endmodule

bind hamming_code_encode_check hce_checker u_hce_checker (.*);
